// File: src/framed_drive_command_decoder_defines.svh
// Assertion macros shared by the framed drive command decoder RTL.
`ifndef FRAMED_DRIVE_COMMAND_DECODER_DEFINES_SVH
`define FRAMED_DRIVE_COMMAND_DECODER_DEFINES_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define FDCD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define FDCD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDCD_ASSERT(lbl, clk, rst_n, prop, msg)
`define FDCD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: src/fdcd_pkg.sv
// Types and constants of the framed drive command decoder.
package fdcd_pkg;

	localparam logic [7:0] STX_BYTE = 8'h02;
	localparam logic [7:0] ETX_BYTE = 8'h03;
	localparam logic [7:0] MAX_LEN  = 8'd10;

	// register indexes of the configuration port
	typedef enum logic [2:0] {
		REG_TIMEOUT_MS,
		REG_DEADBAND,
		REG_TURN_DRIVE,
		REG_COLLECTOR_SPEED,
		REG_LEFT_REST_ANGLE,
		REG_LEFT_FIRE_ANGLE,
		REG_RIGHT_REST_ANGLE,
		REG_RIGHT_FIRE_ANGLE
	} reg_idx_t;

	localparam int unsigned CFG_DATA_W = 16;

	typedef struct packed {
		logic [15:0] timeout_ms;
		logic [7:0]  deadband;
		logic [7:0]  turn_drive;
		logic [7:0]  collector_speed;
		logic [7:0]  left_rest_angle;
		logic [7:0]  left_fire_angle;
		logic [7:0]  right_rest_angle;
		logic [7:0]  right_fire_angle;
	} cfg_t;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] front_left_speed;
		logic [7:0] front_right_speed;
		logic [7:0] rear_left_speed;
		logic [7:0] rear_right_speed;
		logic       front_left_dir;
		logic       front_right_dir;
		logic       rear_left_dir;
		logic       rear_right_dir;
		logic [7:0] left_servo_angle;
		logic [7:0] right_servo_angle;
		logic [7:0] collector_drive;
	} cmd_item_t;

	// result kinds
	localparam logic KIND_COMMAND = 1'b0;
	localparam logic KIND_STOP    = 1'b1;

	// input actions
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// event handed from the parser to the mixer
	typedef struct packed {
		logic              kind;
		logic signed [7:0] x;
		logic signed [7:0] y;
		logic              turn_neg;
		logic              turn_pos;
		logic              left_fire;
		logic              right_fire;
		logic              collecting;
	} evt_t;

endpackage

// File: src/fdcd_chan_if.sv
// Valid/ready channel carrying one payload item per transfer.
interface fdcd_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: src/fdcd_parser.sv
// Frame parser: first register stage, turns bytes and ticks into events.
`include "framed_drive_command_decoder_defines.svh"

module fdcd_parser (
	input  logic            clk,
	input  logic            arst_n,
	input  fdcd_pkg::cfg_t  cfg,
	fdcd_chan_if.sink       rx,
	output logic            evt_valid,
	output fdcd_pkg::evt_t  evt,
	input  logic            evt_ready
);
	import fdcd_pkg::*;

	typedef enum logic [1:0] {PH_IDLE, PH_LEN, PH_DATA} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  flen_q, flen_d;
	logic [7:0]  dcnt_q, dcnt_d;
	logic [7:0]  bytes_q [3];
	logic [7:0]  bytes_d [3];
	logic [15:0] idle_q, idle_d;
	logic        left_launched_q, left_launched_d;
	logic        right_launched_q, right_launched_d;
	logic        collecting_q, collecting_d;
	logic        left_fire_q, left_fire_d;
	logic        right_fire_q, right_fire_d;
	logic        valid_s1;
	evt_t        evt_s1, evt_d;
	logic        acc, emit, take;
	logic        do_stop, do_cmd;
	logic [7:0]  b, fl;

	assign take     = valid_s1 && evt_ready;
	assign rx.ready = !valid_s1 || evt_ready;
	assign acc      = rx.valid && rx.ready;
	assign b        = rx.payload.rx_byte;
	assign fl       = bytes_q[2];

	always_comb begin
		phase_d          = phase_q;
		flen_d           = flen_q;
		dcnt_d           = dcnt_q;
		bytes_d          = bytes_q;
		idle_d           = idle_q;
		left_launched_d  = left_launched_q;
		right_launched_d = right_launched_q;
		collecting_d     = collecting_q;
		left_fire_d      = left_fire_q;
		right_fire_d     = right_fire_q;
		do_stop          = 1'b0;
		do_cmd           = 1'b0;
		if (acc) begin
			if (rx.payload.action == ACT_TICK) begin
				if (phase_q != PH_IDLE) begin
					if (idle_q >= cfg.timeout_ms)
						do_stop = 1'b1;
					else
						idle_d = idle_q + 16'd1;
				end
			end else begin
				idle_d = '0;
				unique case (phase_q)
					PH_IDLE: begin
						if (b != STX_BYTE)
							do_stop = 1'b1;
						else
							phase_d = PH_LEN;
					end
					PH_LEN: begin
						if (b > MAX_LEN) begin
							do_stop = 1'b1;
						end else begin
							flen_d  = b;
							dcnt_d  = '0;
							phase_d = PH_DATA;
						end
					end
					PH_DATA: begin
						if (dcnt_q < flen_q) begin
							if (dcnt_q < 8'd3)
								bytes_d[dcnt_q[1:0]] = b;
							dcnt_d = dcnt_q + 8'd1;
						end else if (b == ETX_BYTE) begin
							do_cmd = 1'b1;
						end else begin
							do_stop = 1'b1;
						end
					end
					default: do_stop = 1'b1;
				endcase
			end
		end
		// both outcomes end the frame
		if (do_stop || do_cmd) begin
			phase_d = PH_IDLE;
			flen_d  = '0;
			dcnt_d  = '0;
			bytes_d = '{default: '0};
		end
		if (do_stop) begin
			idle_d       = '0;
			left_fire_d  = 1'b0;
			right_fire_d = 1'b0;
		end
		if (do_cmd) begin
			if (fl[5]) begin
				left_launched_d = !left_launched_q;
				left_fire_d     = !left_launched_q;
			end
			if (fl[6]) begin
				right_launched_d = !right_launched_q;
				right_fire_d     = !right_launched_q;
			end
			if (fl[7])
				collecting_d = !collecting_q;
		end
		emit             = do_stop || do_cmd;
		evt_d.kind       = do_stop ? KIND_STOP : KIND_COMMAND;
		evt_d.x          = bytes_q[0];
		evt_d.y          = bytes_q[1];
		evt_d.turn_neg   = fl[4] && !fl[3];
		evt_d.turn_pos   = fl[3] && !fl[4];
		evt_d.left_fire  = left_fire_d;
		evt_d.right_fire = right_fire_d;
		evt_d.collecting = collecting_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			flen_q           <= '0;
			dcnt_q           <= '0;
			bytes_q          <= '{default: '0};
			idle_q           <= '0;
			left_launched_q  <= 1'b0;
			right_launched_q <= 1'b0;
			collecting_q     <= 1'b0;
			left_fire_q      <= 1'b0;
			right_fire_q     <= 1'b0;
			valid_s1         <= 1'b0;
			evt_s1           <= '0;
		end else begin
			phase_q          <= phase_d;
			flen_q           <= flen_d;
			dcnt_q           <= dcnt_d;
			bytes_q          <= bytes_d;
			idle_q           <= idle_d;
			left_launched_q  <= left_launched_d;
			right_launched_q <= right_launched_d;
			collecting_q     <= collecting_d;
			left_fire_q      <= left_fire_d;
			right_fire_q     <= right_fire_d;
			if (acc && emit) begin
				valid_s1 <= 1'b1;
				evt_s1   <= evt_d;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign evt_valid = valid_s1;
	assign evt       = evt_s1;

	`FDCD_ASSERT(a_idle_count_clear, clk, arst_n, (phase_q == PH_IDLE) |-> (idle_q == '0), "idle counter running outside a frame")
	`FDCD_ASSERT(a_data_count_bound, clk, arst_n, (dcnt_q <= flen_q) && (flen_q <= MAX_LEN), "data count beyond frame length")
	`FDCD_ASSERT(a_stop_rests_servos, clk, arst_n, (valid_s1 && evt_s1.kind == KIND_STOP) |-> (!evt_s1.left_fire && !evt_s1.right_fire), "safety stop with a servo at fire angle")

endmodule

// File: src/fdcd_mixer.sv
// Wheel mixer and servo selection: second stage, holds the result register.
`include "framed_drive_command_decoder_defines.svh"

module fdcd_mixer (
	input  logic           clk,
	input  logic           arst_n,
	input  fdcd_pkg::cfg_t cfg,
	input  logic           evt_valid,
	input  fdcd_pkg::evt_t evt,
	output logic           evt_ready,
	fdcd_chan_if.source    cmd
);
	import fdcd_pkg::*;

	// 1/sqrt2 in Q16
	localparam logic signed [26:0] MIX_K = 27'sd46341;

	typedef struct packed {
		logic [7:0] spd;
		logic       neg;
	} whl_t;

	// truncate toward zero, apply dead zone and clamp
	function automatic whl_t wheel(input logic signed [26:0] q, input logic [7:0] dz);
		logic [26:0] mag;
		logic [9:0]  m;
		whl_t        w;
		mag   = q[26] ? 27'(-q) : 27'(q);
		m     = mag[25:16];
		w.neg = q[26] && (m > {2'b00, dz});
		if (m <= {2'b00, dz})
			w.spd = '0;
		else if (m > 10'd255)
			w.spd = 8'hFF;
		else
			w.spd = m[7:0];
		return w;
	endfunction

	logic                valid_s2;
	cmd_item_t           res_s2, res_d;
	logic signed [9:0]   s_sum, s_dif, t;
	logic signed [26:0]  p_sum, p_dif, tq;
	whl_t                w_fl, w_fr, w_rl, w_rr;

	assign evt_ready = !valid_s2 || cmd.ready;

	always_comb begin
		s_sum = 10'(evt.x) + 10'(evt.y);
		s_dif = 10'(evt.y) - 10'(evt.x);
		if (evt.turn_neg)
			t = -$signed({2'b00, cfg.turn_drive});
		else if (evt.turn_pos)
			t = $signed({2'b00, cfg.turn_drive});
		else
			t = '0;
		p_sum = 27'(s_sum) * MIX_K;
		p_dif = 27'(s_dif) * MIX_K;
		tq    = 27'(t) <<< 16;
		w_fl  = wheel(p_sum + tq, cfg.deadband);
		w_fr  = wheel(p_dif - tq, cfg.deadband);
		w_rl  = wheel(tq - p_sum, cfg.deadband);
		w_rr  = wheel(-p_dif - tq, cfg.deadband);

		res_d = '0;
		res_d.kind = evt.kind;
		if (evt.kind == KIND_STOP) begin
			res_d.left_servo_angle  = cfg.left_rest_angle;
			res_d.right_servo_angle = cfg.right_rest_angle;
		end else begin
			res_d.front_left_speed  = w_fl.spd;
			res_d.front_right_speed = w_fr.spd;
			res_d.rear_left_speed   = w_rl.spd;
			res_d.rear_right_speed  = w_rr.spd;
			res_d.front_left_dir    = w_fl.neg;
			res_d.front_right_dir   = !w_fr.neg;
			res_d.rear_left_dir     = w_rl.neg;
			res_d.rear_right_dir    = !w_rr.neg;
			res_d.left_servo_angle  = evt.left_fire ? cfg.left_fire_angle
				: cfg.left_rest_angle;
			res_d.right_servo_angle = evt.right_fire ? cfg.right_fire_angle
				: cfg.right_rest_angle;
			res_d.collector_drive   = evt.collecting ? cfg.collector_speed : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (evt_ready) begin
			valid_s2 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready)
			res_s2 <= res_d;
	end

	assign cmd.valid   = valid_s2;
	assign cmd.payload = res_s2;

	`FDCD_ASSERT(a_stop_motors_off, clk, arst_n, (valid_s2 && res_s2.kind == KIND_STOP) |-> ((res_s2.front_left_speed | res_s2.front_right_speed | res_s2.rear_left_speed | res_s2.rear_right_speed | res_s2.collector_drive) == 8'd0), "safety stop with a motor driven")

endmodule

// File: src/framed_drive_command_decoder.sv
// Top level of the framed drive command decoder.
// Each input transfer on rx is either a received serial byte or a one
// millisecond tick. Bytes are parsed as frames: 0x02, a length byte (at most
// 10), that many data bytes (stick x, stick y, flags; further bytes are
// counted and dropped, missing ones read as zero), then 0x03. A complete
// frame gives one command result on cmd: four omni wheel speeds and
// directions mixed at 1/sqrt2 with a turn term, dead zone and clamp, the
// launcher servo angles and the collector drive. A bad byte, or a tick once
// the idle count inside a frame has reached timeout_ms, resets the parser
// and gives a safety stop result with all motors at zero and both servos at
// rest. Ticks outside a frame give nothing. Rate: one transfer per clock
// cycle while rx.ready is high; a result goes from its transfer through the
// parser register stage and the mixer result register. The result register
// parts the two sides, so while a result waits for cmd.ready rx keeps
// taking items until a second result is held in the parser stage.
// Configuration registers are written through wr_en, wr_index and wr_data,
// by the user only while the block is idle; the block does not enforce it.
module framed_drive_command_decoder (
	input  logic                              clk,
	input  logic                              arst_n,
	fdcd_chan_if.sink                         rx,
	fdcd_chan_if.source                       cmd,
	input  logic                              wr_en,
	input  logic [2:0]                        wr_index,
	input  logic [fdcd_pkg::CFG_DATA_W-1:0]   wr_data
);
	import fdcd_pkg::*;

	cfg_t cfg_q;
	logic evt_valid, evt_ready;
	evt_t evt;

	// Configuration registers: take each write at once, keep the low bits
	// that the register holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms       <= 16'd10000;
			cfg_q.deadband         <= 8'd30;
			cfg_q.turn_drive       <= 8'd64;
			cfg_q.collector_speed  <= 8'd64;
			cfg_q.left_rest_angle  <= 8'd180;
			cfg_q.left_fire_angle  <= 8'd90;
			cfg_q.right_rest_angle <= 8'd90;
			cfg_q.right_fire_angle <= 8'd180;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_TIMEOUT_MS:       cfg_q.timeout_ms       <= wr_data[15:0];
				REG_DEADBAND:         cfg_q.deadband         <= wr_data[7:0];
				REG_TURN_DRIVE:       cfg_q.turn_drive       <= wr_data[7:0];
				REG_COLLECTOR_SPEED:  cfg_q.collector_speed  <= wr_data[7:0];
				REG_LEFT_REST_ANGLE:  cfg_q.left_rest_angle  <= wr_data[7:0];
				REG_LEFT_FIRE_ANGLE:  cfg_q.left_fire_angle  <= wr_data[7:0];
				REG_RIGHT_REST_ANGLE: cfg_q.right_rest_angle <= wr_data[7:0];
				REG_RIGHT_FIRE_ANGLE: cfg_q.right_fire_angle <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	// Stage 1: parse the transfer, update frame and launcher state, and
	// hold an event when a frame ends or is aborted.
	fdcd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.rx        (rx),
		.evt_valid (evt_valid),
		.evt       (evt),
		.evt_ready (evt_ready)
	);

	// Stage 2: mix the wheels, pick servo angles and hold the result until
	// the sink takes it.
	fdcd_mixer u_mixer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.evt_valid (evt_valid),
		.evt       (evt),
		.evt_ready (evt_ready),
		.cmd       (cmd)
	);

endmodule

// File: test/tb.sv
// Self-checking testbench for the framed drive command decoder.
module tb;
	import fdcd_pkg::*;

	// Quiet cycles (no transfer on either channel) before the run is abandoned.
	localparam int QUIET_LIMIT   = 2000;
	// A result passes the parser and mixer registers; leave a margin before touching registers.
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 700;

	typedef enum logic [1:0] {AWAIT_STX, AWAIT_LEN, IN_FRAME} parse_phase_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [2:0] wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	fdcd_chan_if #(.payload_t(rx_item_t)) rx_ch ();
	fdcd_chan_if #(.payload_t(cmd_item_t)) cmd_ch ();

	framed_drive_command_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.cmd     (cmd_ch),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow of the decoder: registers, parser and launcher/collector state
	// ------------------------------------------------------------------
	cfg_t         shadow_cfg;
	parse_phase_t phase;
	logic [7:0]   frame_len;
	logic [7:0]   data_seen;
	logic [7:0]   stick [3];
	logic [15:0]  idle_ms;
	logic         left_launched, right_launched, collecting;
	logic         left_at_fire, right_at_fire;

	cmd_item_t pending_cmds [$];

	int  fault_count;
	int  busy_items;
	int  cmd_count;
	int  stop_count;
	int  cfg_phases;
	bit  src_live, sink_live;
	bit  src_idle_on, sink_idle_on;

	function automatic void parser_reset();
		phase     = AWAIT_STX;
		frame_len = '0;
		data_seen = '0;
		stick[0]  = '0;
		stick[1]  = '0;
		stick[2]  = '0;
	endfunction

	// (a * 46341 + t * 65536) / 65536, truncated toward zero
	function automatic int omni_mix(input int a, input int t);
		int q;
		q = a * 46341 + t * 65536;
		if (q < 0)
			return -((-q) >>> 16);
		return q >>> 16;
	endfunction

	// Dead zone, then clamp with the sign kept; zero counts as forward.
	function automatic void drive_wheel(input int v, input bit neg_dir,
			output logic [7:0] spd, output logic dir);
		int m;
		m = (v < 0) ? -v : v;
		if (m <= int'(shadow_cfg.deadband)) begin
			v = 0;
			m = 0;
		end
		if (m > 255)
			m = 255;
		spd = m[7:0];
		dir = (v < 0) ? neg_dir : !neg_dir;
	endfunction

	function automatic bit safety_stop(output cmd_item_t res);
		parser_reset();
		idle_ms       = '0;
		left_at_fire  = 1'b0;
		right_at_fire = 1'b0;
		res                   = '0;
		res.kind              = KIND_STOP;
		res.left_servo_angle  = shadow_cfg.left_rest_angle;
		res.right_servo_angle = shadow_cfg.right_rest_angle;
		return 1'b1;
	endfunction

	function automatic bit build_command(output cmd_item_t res);
		int x, y, t;
		logic [7:0] f;
		x = int'($signed(stick[0]));
		y = int'($signed(stick[1]));
		f = stick[2];
		t = 0;
		parser_reset();
		// turn left on bit 4 alone, right on bit 3 alone, none when both
		if (f[4] && !f[3])
			t = -int'(shadow_cfg.turn_drive);
		else if (f[3] && !f[4])
			t = int'(shadow_cfg.turn_drive);
		res      = '0;
		res.kind = KIND_COMMAND;
		drive_wheel(omni_mix(x + y, t), 1'b1, res.front_left_speed, res.front_left_dir);
		drive_wheel(omni_mix(-x + y, -t), 1'b0, res.front_right_speed, res.front_right_dir);
		drive_wheel(omni_mix(-x - y, t), 1'b1, res.rear_left_speed, res.rear_left_dir);
		drive_wheel(omni_mix(x - y, -t), 1'b0, res.rear_right_speed, res.rear_right_dir);
		if (f[5]) begin
			left_launched = !left_launched;
			left_at_fire  = left_launched;
		end
		if (f[6]) begin
			right_launched = !right_launched;
			right_at_fire  = right_launched;
		end
		if (f[7])
			collecting = !collecting;
		res.left_servo_angle  = left_at_fire ? shadow_cfg.left_fire_angle
			: shadow_cfg.left_rest_angle;
		res.right_servo_angle = right_at_fire ? shadow_cfg.right_fire_angle
			: shadow_cfg.right_rest_angle;
		res.collector_drive   = collecting ? shadow_cfg.collector_speed : 8'd0;
		return 1'b1;
	endfunction

	// Advance the shadow by one rx transfer; returns 1 when a result is due.
	function automatic bit decode_rx(input logic act, input logic [7:0] b,
			output cmd_item_t res);
		res = '0;
		if (act == ACT_TICK) begin
			if (phase == AWAIT_STX)
				return 1'b0;
			if (idle_ms >= shadow_cfg.timeout_ms)
				return safety_stop(res);
			idle_ms++;
			return 1'b0;
		end
		idle_ms = '0;
		case (phase)
			AWAIT_STX: begin
				if (b != STX_BYTE)
					return safety_stop(res);
				phase = AWAIT_LEN;
				return 1'b0;
			end
			AWAIT_LEN: begin
				if (b > MAX_LEN)
					return safety_stop(res);
				frame_len = b;
				data_seen = '0;
				phase     = IN_FRAME;
				return 1'b0;
			end
			default: begin
				if (data_seen < frame_len) begin
					// bytes past the flags byte are counted and dropped
					if (data_seen < 8'd3)
						stick[data_seen[1:0]] = b;
					data_seen++;
					return 1'b0;
				end
				if (b == ETX_BYTE)
					return build_command(res);
				return safety_stop(res);
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic int pick_gap(input bit on);
		return on ? $urandom_range(0, 8) : 0;
	endfunction

	// Send one rx item and hold until it transfers; valid stays high when the
	// next item follows without a gap.
	task automatic push_rx(input logic act, input logic [7:0] b);
		int gap;
		bit ignored;
		bit due;
		cmd_item_t res;
		gap = pick_gap(src_idle_on);
		if (gap != 0) begin
			if (src_live)
				rx_ch.valid <= 1'b0;
			src_live = 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.payload <= rx_item_t'{action: act, rx_byte: b};
		src_live = 1'b1;
		@(posedge clk);
		while (!rx_ch.ready)
			@(posedge clk);
		ignored = (act == ACT_TICK) && (phase == AWAIT_STX);
		due = decode_rx(act, b, res);
		if (!ignored)
			busy_items++;
		if (due) begin
			pending_cmds.push_back(res);
			if (res.kind == KIND_STOP)
				stop_count++;
			else
				cmd_count++;
		end
	endtask

	// Drop valid, drain every owed result, then let the pipeline empty.
	task automatic quiesce();
		if (src_live)
			rx_ch.valid <= 1'b0;
		src_live = 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input reg_idx_t idx, input logic [15:0] v);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= v;
		@(posedge clk);
		case (idx)
			REG_TIMEOUT_MS:       shadow_cfg.timeout_ms       = v;
			REG_DEADBAND:         shadow_cfg.deadband         = v[7:0];
			REG_TURN_DRIVE:       shadow_cfg.turn_drive       = v[7:0];
			REG_COLLECTOR_SPEED:  shadow_cfg.collector_speed  = v[7:0];
			REG_LEFT_REST_ANGLE:  shadow_cfg.left_rest_angle  = v[7:0];
			REG_LEFT_FIRE_ANGLE:  shadow_cfg.left_fire_angle  = v[7:0];
			REG_RIGHT_REST_ANGLE: shadow_cfg.right_rest_angle = v[7:0];
			REG_RIGHT_FIRE_ANGLE: shadow_cfg.right_fire_angle = v[7:0];
			default: ;
		endcase
	endtask

	// Write the whole register set while the block is idle.
	task automatic reconfigure(input cfg_t c);
		quiesce();
		set_reg(REG_TIMEOUT_MS, c.timeout_ms);
		set_reg(REG_DEADBAND, {8'h00, c.deadband});
		set_reg(REG_TURN_DRIVE, {8'h00, c.turn_drive});
		set_reg(REG_COLLECTOR_SPEED, {8'h00, c.collector_speed});
		set_reg(REG_LEFT_REST_ANGLE, {8'h00, c.left_rest_angle});
		set_reg(REG_LEFT_FIRE_ANGLE, {8'h00, c.left_fire_angle});
		set_reg(REG_RIGHT_REST_ANGLE, {8'h00, c.right_rest_angle});
		set_reg(REG_RIGHT_FIRE_ANGLE, {8'h00, c.right_fire_angle});
		wr_en <= 1'b0;
		cfg_phases++;
	endtask

	// Lean towards the ends of the range now and then.
	function automatic logic [7:0] span_pick(input int hi);
		case ($urandom_range(0, 5))
			0:       return 8'd0;
			1:       return 8'(hi);
			default: return 8'($urandom_range(0, hi));
		endcase
	endfunction

	function automatic cfg_t random_cfg(input int round);
		cfg_t c;
		if (round == 0) begin
			c = '0;
		end else if (round == 1) begin
			c = '{16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd180, 8'd180, 8'd180, 8'd180};
		end else begin
			case ($urandom_range(0, 3))
				0:       c.timeout_ms = 16'($urandom_range(0, 3));
				1, 2:    c.timeout_ms = 16'($urandom_range(4, 30));
				default: c.timeout_ms = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'($urandom);
			endcase
			c.deadband         = span_pick(255);
			c.turn_drive       = span_pick(255);
			c.collector_speed  = span_pick(255);
			c.left_rest_angle  = span_pick(180);
			c.left_fire_angle  = span_pick(180);
			c.right_rest_angle = span_pick(180);
			c.right_fire_angle = span_pick(180);
		end
		return c;
	endfunction

	function automatic logic [7:0] stick_value();
		case ($urandom_range(0, 11))
			0:       return 8'h80;
			1:       return 8'h7F;
			2:       return 8'h00;
			3:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// A byte of a frame, sometimes preceded by a few ticks.
	task automatic frame_byte(input logic [7:0] b);
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3)) push_rx(ACT_TICK, 8'($urandom));
		push_rx(ACT_BYTE, b);
	endtask

	task automatic send_random_sequence();
		int pick, n, k;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			// well-formed frame, usually the full three data bytes
			n = ($urandom_range(0, 2) != 0) ? 3 : $urandom_range(0, MAX_LEN);
			frame_byte(STX_BYTE);
			frame_byte(8'(n));
			for (k = 0; k < n; k++)
				frame_byte((k < 2) ? stick_value() : 8'($urandom));
			frame_byte(ETX_BYTE);
		end else if (pick < 78) begin
			// length over the limit
			frame_byte(STX_BYTE);
			frame_byte(8'($urandom_range(MAX_LEN + 1, 255)));
		end else if (pick < 86) begin
			// full frame with a wrong closing byte
			n = $urandom_range(0, MAX_LEN);
			frame_byte(STX_BYTE);
			frame_byte(8'(n));
			for (k = 0; k < n; k++)
				frame_byte(8'($urandom));
			b = 8'($urandom);
			if (b == ETX_BYTE)
				b = 8'hFF;
			frame_byte(b);
		end else if (pick < 93) begin
			// line noise
			repeat ($urandom_range(1, 3)) push_rx(ACT_BYTE, 8'($urandom));
		end else begin
			// sender goes quiet inside a frame and only ticks arrive
			frame_byte(STX_BYTE);
			if ($urandom_range(0, 1) != 0)
				frame_byte(8'($urandom_range(0, MAX_LEN)));
			repeat ($urandom_range(0, 40)) push_rx(ACT_TICK, 8'($urandom));
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Reset defaults: stray byte, idle tick, overlong length, empty frame,
	// full frame with every toggle, extra data, wrong end byte.
	task automatic test_frame_basics();
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		push_rx(ACT_BYTE, 8'hFF);
		push_rx(ACT_TICK, 8'h00);
		push_rx(ACT_BYTE, STX_BYTE);
		push_rx(ACT_BYTE, MAX_LEN + 8'd1);
		push_rx(ACT_BYTE, STX_BYTE);
		push_rx(ACT_BYTE, 8'd0);
		push_rx(ACT_BYTE, ETX_BYTE);
		push_rx(ACT_BYTE, STX_BYTE);
		push_rx(ACT_BYTE, 8'd3);
		push_rx(ACT_BYTE, 8'h7F);
		push_rx(ACT_BYTE, 8'h7F);
		push_rx(ACT_BYTE, 8'hE8);
		push_rx(ACT_BYTE, ETX_BYTE);
		push_rx(ACT_BYTE, STX_BYTE);
		push_rx(ACT_BYTE, 8'd4);
		push_rx(ACT_BYTE, 8'h80);
		push_rx(ACT_BYTE, 8'h80);
		push_rx(ACT_BYTE, 8'h10);
		push_rx(ACT_BYTE, 8'h55);
		push_rx(ACT_BYTE, ETX_BYTE);
		push_rx(ACT_BYTE, STX_BYTE);
		push_rx(ACT_BYTE, 8'd1);
		push_rx(ACT_BYTE, 8'h05);
		push_rx(ACT_BYTE, 8'hFF);
	endtask

	// Idle timeout inside a frame: immediate at zero, and a byte that
	// restarts the count before the limit is reached.
	task automatic test_idle_timeout();
		cfg_t c;
		c = shadow_cfg;
		c.timeout_ms = 16'd0;
		reconfigure(c);
		push_rx(ACT_BYTE, STX_BYTE);
		push_rx(ACT_TICK, 8'hFF);
		c.timeout_ms = 16'd2;
		reconfigure(c);
		push_rx(ACT_BYTE, STX_BYTE);
		push_rx(ACT_TICK, 8'h00);
		push_rx(ACT_TICK, 8'h00);
		push_rx(ACT_BYTE, 8'd3);
		repeat (3) push_rx(ACT_TICK, 8'h00);
	endtask

	// Rounds of random traffic, each under fresh register settings; the
	// drain before every write set makes the sender wait for all results.
	task automatic test_random_traffic();
		int base, round;
		base  = busy_items;
		round = 0;
		while (busy_items - base < RANDOM_ITEMS) begin
			reconfigure(random_cfg(round));
			src_idle_on  = ($urandom_range(0, 3) != 0);
			sink_idle_on = ($urandom_range(0, 3) != 0);
			repeat (10) send_random_sequence();
			round++;
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: random back-pressure and field-by-field comparison
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			fault_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	task automatic compare_cmd(input cmd_item_t want, input cmd_item_t got);
		check_field("kind", {7'd0, want.kind}, {7'd0, got.kind});
		check_field("front_left_speed", want.front_left_speed, got.front_left_speed);
		check_field("front_right_speed", want.front_right_speed, got.front_right_speed);
		check_field("rear_left_speed", want.rear_left_speed, got.rear_left_speed);
		check_field("rear_right_speed", want.rear_right_speed, got.rear_right_speed);
		check_field("front_left_dir", {7'd0, want.front_left_dir},
			{7'd0, got.front_left_dir});
		check_field("front_right_dir", {7'd0, want.front_right_dir},
			{7'd0, got.front_right_dir});
		check_field("rear_left_dir", {7'd0, want.rear_left_dir},
			{7'd0, got.rear_left_dir});
		check_field("rear_right_dir", {7'd0, want.rear_right_dir},
			{7'd0, got.rear_right_dir});
		check_field("left_servo_angle", want.left_servo_angle, got.left_servo_angle);
		check_field("right_servo_angle", want.right_servo_angle, got.right_servo_angle);
		check_field("collector_drive", want.collector_drive, got.collector_drive);
	endtask

	initial begin : result_sink
		int stall;
		cmd_ch.ready <= 1'b0;
		sink_live = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = pick_gap(sink_idle_on);
			if (stall != 0) begin
				if (sink_live)
					cmd_ch.ready <= 1'b0;
				sink_live = 1'b0;
				repeat (stall) @(posedge clk);
			end
			cmd_ch.ready <= 1'b1;
			sink_live = 1'b1;
			@(posedge clk);
			while (!cmd_ch.valid)
				@(posedge clk);
			// one transfer on cmd at this edge
			if (pending_cmds.size() == 0) begin
				fault_count++;
				$display("%0t: unexpected result, expected none, actual kind %0d",
					$time, cmd_ch.payload.kind);
			end else begin
				compare_cmd(pending_cmds.pop_front(), cmd_ch.payload);
			end
		end
	end

	// Abandon the run when neither channel has moved for too long.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((rx_ch.valid && rx_ch.ready) || (cmd_ch.valid && cmd_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_seq
		arst_n        <= 1'b0;
		rx_ch.valid   <= 1'b0;
		rx_ch.payload <= '0;
		wr_en         <= 1'b0;
		wr_index      <= '0;
		wr_data       <= '0;
		fault_count   = 0;
		busy_items    = 0;
		cmd_count     = 0;
		stop_count    = 0;
		cfg_phases    = 0;
		src_live      = 1'b0;
		src_idle_on   = 1'b1;
		sink_idle_on  = 1'b1;
		// reset values of the register set and the decoder state
		shadow_cfg = '{16'd10000, 8'd30, 8'd64, 8'd64, 8'd180, 8'd90, 8'd90, 8'd180};
		parser_reset();
		idle_ms        = '0;
		left_launched  = 1'b0;
		right_launched = 1'b0;
		collecting     = 1'b0;
		left_at_fire   = 1'b0;
		right_at_fire  = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_frame_basics();
		test_idle_timeout();
		test_random_traffic();

		// hold until every owed result has arrived, then let the block settle
		quiesce();
		$display("Covered %0d decoder items over %0d register settings:", busy_items,
			cfg_phases);
		$display("  %0d command results and %0d safety stops checked.", cmd_count,
			stop_count);
		if (fault_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// File: files.f
+incdir+src
src/fdcd_pkg.sv
src/fdcd_chan_if.sv
src/fdcd_parser.sv
src/fdcd_mixer.sv
src/framed_drive_command_decoder.sv
test/tb.sv
